// File: design/sllc_pkg.sv
// Package for the stop-line lap counter: beat structs, status codes and
// configuration register indexes. No dependencies.
`default_nettype none

package sllc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 31;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DIRECT_STOP_MODE = 3'd0,
    CFG_TARGET_LAPS      = 3'd1,
    CFG_PASS_GAP_FRAMES  = 3'd2,
    CFG_WARMUP_FRAMES    = 3'd3,
    CFG_STOP_DISTANCE    = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [7:0]  TargetLapsReset    = 8'd1;
  localparam logic [7:0]  PassGapFramesReset = 8'd30;
  localparam logic [7:0]  WarmupFramesReset  = 8'd10;
  localparam logic [30:0] StopDistanceReset  = 31'd40000;

  localparam logic [7:0] CountMax = 8'd255;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_SEEN    = 2'd1,
    MARK_STOPPED = 2'd2
  } marker_t;

  typedef enum logic [1:0] {
    LAP_NONE   = 2'd0,
    LAP_SEEN   = 2'd1,
    LAP_FINAL  = 2'd2,
    LAP_PASSED = 2'd3
  } lap_t;

  typedef enum logic {
    MODE_FRAME = 1'b0,
    MODE_CLEAR = 1'b1
  } item_mode_t;

  typedef struct packed {
    item_mode_t         mode;
    logic               stripe_detected;
    logic signed [31:0] encoder_position;
  } in_beat_t;

  typedef struct packed {
    marker_t    marker_flag;
    lap_t       lap_state;
    logic [7:0] crossing_count;
    logic       delay_active;
    logic       beep_start;
    logic       stop_now;
    logic       clear_landmarks;
  } out_beat_t;

endpackage

`default_nettype wire

// File: design/stop_line_lap_counter.sv
// Stop-line lap counter: one input register, one step of state update logic
// and a result register. Each input beat passes through the input register
// and then the result register; one beat accepted every cycle while the
// result side keeps taking beats.
// Synchronous active-high reset clears the counters, flags, start position
// and both valid bits, and restores the configuration register defaults.
// Depends on sllc_pkg.
`default_nettype none

module stop_line_lap_counter
  import sllc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_beat_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_beat_t                     out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers. Always ready; the user must write only when idle,
  // as the block itself does not enforce it.
  logic        direct_stop_mode;
  logic [7:0]  target_laps;
  logic [7:0]  pass_gap_frames;
  logic [7:0]  warmup_frames;
  logic [30:0] stop_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_stop_mode <= 1'b0;
      target_laps      <= TargetLapsReset;
      pass_gap_frames  <= PassGapFramesReset;
      warmup_frames    <= WarmupFramesReset;
      stop_distance    <= StopDistanceReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRECT_STOP_MODE: direct_stop_mode <= cfg_data[0];
        CFG_TARGET_LAPS:      target_laps      <= cfg_data[7:0];
        CFG_PASS_GAP_FRAMES:  pass_gap_frames  <= cfg_data[7:0];
        CFG_WARMUP_FRAMES:    warmup_frames    <= cfg_data[7:0];
        CFG_STOP_DISTANCE:    stop_distance    <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register. Moves on whenever the result register can take a beat,
  // so a new beat lands every cycle under no back-pressure.
  // ---------------------------------------------------------------------
  logic     stage_valid;
  in_beat_t stage_item;
  logic     advance;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------
  logic        [7:0]  frame_counter;
  logic               waiting_pass;
  logic        [7:0]  gap_counter;
  logic        [7:0]  crossings;
  lap_t               lap_phase;
  logic               delaying;
  logic signed [31:0] start_position;
  marker_t            flag_state;

  logic        [7:0]  frame_counter_next;
  logic               waiting_pass_next;
  logic        [7:0]  gap_counter_next;
  logic        [7:0]  crossings_next;
  lap_t               lap_phase_next;
  logic               delaying_next;
  logic signed [31:0] start_position_next;
  marker_t            flag_state_next;
  logic               beep;
  logic               stopped;
  logic               clr;

  // Travel since the delay began: 33-bit signed difference, then magnitude.
  logic signed [32:0] travel;
  logic        [32:0] travel_mag;

  assign travel     = {stage_item.encoder_position[31], stage_item.encoder_position}
                    - {start_position[31], start_position};
  assign travel_mag = travel[32] ? 33'(-travel) : 33'(travel);

  always_comb begin
    frame_counter_next  = frame_counter;
    waiting_pass_next   = waiting_pass;
    gap_counter_next    = gap_counter;
    crossings_next      = crossings;
    lap_phase_next      = lap_phase;
    delaying_next       = delaying;
    start_position_next = start_position;
    flag_state_next     = flag_state;
    beep                = 1'b0;
    stopped             = 1'b0;
    clr                 = 1'b0;

    if (stage_item.mode == MODE_CLEAR) begin
      // clear keeps frame count, start position and the stopped flag
      lap_phase_next    = LAP_NONE;
      gap_counter_next  = '0;
      crossings_next    = '0;
      waiting_pass_next = 1'b0;
      delaying_next     = 1'b0;
    end else begin
      // distance check first
      if (delaying && (travel_mag >= {2'b00, stop_distance})) begin
        delaying_next   = 1'b0;
        flag_state_next = MARK_STOPPED;
        stopped         = 1'b1;
      end

      if (!delaying_next && flag_state_next != MARK_STOPPED) begin
        if (frame_counter != CountMax) begin
          frame_counter_next = frame_counter + 8'd1;
        end

        if (frame_counter >= warmup_frames) begin
          if (direct_stop_mode) begin
            // direct mode: lap state and marker untouched
            if (stage_item.stripe_detected) begin
              delaying_next       = 1'b1;
              start_position_next = stage_item.encoder_position;
              beep                = 1'b1;
            end
          end else begin
            if (stage_item.stripe_detected) begin
              gap_counter_next = '0;
              if (!waiting_pass) begin
                // new crossing
                if (crossings != CountMax) begin
                  crossings_next = crossings + 8'd1;
                end
                waiting_pass_next = 1'b1;
                if ({1'b0, crossings_next} >= ({1'b0, target_laps} + 9'd1)) begin
                  delaying_next       = 1'b1;
                  start_position_next = stage_item.encoder_position;
                  beep                = 1'b1;
                  lap_phase_next      = LAP_FINAL;
                  clr                 = 1'b1;
                end else begin
                  lap_phase_next = LAP_SEEN;
                end
              end
            end else if (waiting_pass) begin
              if (gap_counter != CountMax) begin
                gap_counter_next = gap_counter + 8'd1;
              end
              if (gap_counter_next >= pass_gap_frames) begin
                // gap long enough: re-arm for the next crossing
                gap_counter_next  = '0;
                waiting_pass_next = 1'b0;
                lap_phase_next    = LAP_PASSED;
              end
            end

            // marker follows the count only while neither delaying nor stopped
            if (!delaying_next) begin
              flag_state_next = (crossings_next == '0) ? MARK_NONE : MARK_SEEN;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter  <= '0;
      waiting_pass   <= 1'b0;
      gap_counter    <= '0;
      crossings      <= '0;
      lap_phase      <= LAP_NONE;
      delaying       <= 1'b0;
      start_position <= '0;
      flag_state     <= MARK_NONE;
    end else if (advance) begin
      frame_counter  <= frame_counter_next;
      waiting_pass   <= waiting_pass_next;
      gap_counter    <= gap_counter_next;
      crossings      <= crossings_next;
      lap_phase      <= lap_phase_next;
      delaying       <= delaying_next;
      start_position <= start_position_next;
      flag_state     <= flag_state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.marker_flag     <= flag_state_next;
      out_data.lap_state       <= lap_phase_next;
      out_data.crossing_count  <= crossings_next;
      out_data.delay_active    <= delaying_next;
      out_data.beep_start      <= beep;
      out_data.stop_now        <= stopped;
      out_data.clear_landmarks <= clr;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_stop_marks_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stop_now |-> out_data.marker_flag == MARK_STOPPED)
    else $error("stop pulse without stopped marker");

  a_beep_not_with_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.beep_start && out_data.stop_now))
    else $error("beep and stop in one result");

  a_beep_sets_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.beep_start |-> out_data.delay_active)
    else $error("beep without delay phase");

  a_clear_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clear_landmarks |-> out_data.lap_state == LAP_FINAL)
    else $error("landmark clear outside final crossing");

  a_stopped_not_delaying: assert property (@(posedge clk) disable iff (rst)
    flag_state == MARK_STOPPED && stage_item.mode == MODE_FRAME && advance
      |=> !delaying)
    else $error("delay restarted after stop");

endmodule

`default_nettype wire
